// ===== rtl/core/rc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rc_pkg
// Shared types, symbol codes and the digit-to-character function of the radix
// converter.
// ----------------------------------------------------------------------------
package rc_pkg;

  localparam int DIGIT_WIDTH = 16;
  localparam int KIND_WIDTH  = 3;
  localparam int CHAR_WIDTH  = 7;
  localparam int FD_WIDTH    = 5;
  localparam int MCNT_WIDTH  = $clog2(DIGIT_WIDTH);

  localparam logic [FD_WIDTH-1:0] FD_RESET = 5'd4;

  localparam logic [KIND_WIDTH-1:0] KIND_MINUS = 3'd0;
  localparam logic [KIND_WIDTH-1:0] KIND_INT   = 3'd1;
  localparam logic [KIND_WIDTH-1:0] KIND_POINT = 3'd2;
  localparam logic [KIND_WIDTH-1:0] KIND_FRAC  = 3'd3;
  localparam logic [KIND_WIDTH-1:0] KIND_BAD   = 3'd4;

  localparam logic [DIGIT_WIDTH-1:0] BASE_MIN   = 16'd2;
  localparam logic [DIGIT_WIDTH-1:0] BASE_ASCII = 16'd62;
  localparam logic [CHAR_WIDTH-1:0]  CHAR_MINUS = 7'd45;
  localparam logic [CHAR_WIDTH-1:0]  CHAR_POINT = 7'd46;

  typedef struct packed {
    logic                  load;
    logic                  div_init;
    logic                  div_step;
    logic                  store;
    logic                  rd;
    logic                  mul_init;
    logic                  mul_step;
    logic                  frac_next;
    logic                  emit;
    logic [KIND_WIDTH-1:0] kind;
    logic                  last;
  } rc_cmd_t;

  typedef struct packed {
    logic bad_base;
    logic neg_nz;
    logic frac_nz;
    logic div_last;
    logic quot_zero;
    logic count_zero;
    logic frac_left_zero;
    logic frac_left_one;
    logic mul_last;
  } rc_status_t;

  function automatic logic [CHAR_WIDTH-1:0] ascii_of(input logic [DIGIT_WIDTH-1:0] d,
                                                     input logic base_small);
    logic [DIGIT_WIDTH-1:0] c;
    begin
      if (!base_small) begin
        c = '0;
      end else if (d < 16'd10) begin
        c = d + 16'd48;
      end else if (d <= 16'd35) begin
        c = d + 16'd55;
      end else begin
        c = d + 16'd61;
      end
      return c[CHAR_WIDTH-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/radix_converter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// radix_converter
// Converts a sign-magnitude number with a fixed-point fraction into a stream
// of digit symbols in a selectable base.
// ----------------------------------------------------------------------------
// A conversion starts at a clock edge with start high and busy low. Symbols
// leave one per strobe on symbol_valid, each for one cycle only, and the
// receiver cannot stall them. A base below 2 produces its single error symbol
// in the cycle after start and busy stays low. Otherwise busy is high for the
// whole conversion, which runs the bit-serial divider, one quotient bit per
// cycle for every integer digit, and, when the fraction is nonzero, the
// shift-add multiplier, one base bit per cycle for every fraction digit.
// frac_digits is written through its valid/ready channel while busy is low.
// ----------------------------------------------------------------------------
module radix_converter import rc_pkg::*; #(
  parameter int INT_WIDTH       = 31,
  parameter int FRAC_WIDTH      = 32,
  parameter int MAX_FRAC_DIGITS = 16
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     start,
  output logic                    busy,
  input  wire                     negative,
  input  wire  [INT_WIDTH-1:0]    int_magnitude,
  input  wire  [FRAC_WIDTH-1:0]   fraction,
  input  wire  [DIGIT_WIDTH-1:0]  target_base,
  input  wire                     frac_digits_valid,
  output logic                    frac_digits_ready,
  input  wire  [FD_WIDTH-1:0]     frac_digits,
  output logic                    symbol_valid,
  output logic [KIND_WIDTH-1:0]   symbol_kind,
  output logic [DIGIT_WIDTH-1:0]  digit_value,
  output logic [CHAR_WIDTH-1:0]   char_code,
  output logic                    last_symbol
);

  rc_cmd_t    cmd;
  rc_status_t status;

  assign frac_digits_ready = !busy;

  rc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  rc_datapath #(
    .INT_WIDTH       (INT_WIDTH),
    .FRAC_WIDTH      (FRAC_WIDTH),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .negative      (negative),
    .int_magnitude (int_magnitude),
    .fraction      (fraction),
    .target_base   (target_base),
    .cfg_we        (frac_digits_valid && frac_digits_ready),
    .cfg_data      (frac_digits),
    .cmd           (cmd),
    .status        (status),
    .symbol_valid  (symbol_valid),
    .symbol_kind   (symbol_kind),
    .digit_value   (digit_value),
    .char_code     (char_code),
    .last_symbol   (last_symbol)
  );

endmodule
`default_nettype wire

// ===== rtl/core/rc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rc_datapath
// Bit-serial divider, digit buffer, shift-add multiplier, frac_digits register
// and the registered symbol output.
// ----------------------------------------------------------------------------
module rc_datapath import rc_pkg::*; #(
  parameter int INT_WIDTH       = 31,
  parameter int FRAC_WIDTH      = 32,
  parameter int MAX_FRAC_DIGITS = 16
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        negative,
  input  wire  [INT_WIDTH-1:0]       int_magnitude,
  input  wire  [FRAC_WIDTH-1:0]      fraction,
  input  wire  [DIGIT_WIDTH-1:0]     target_base,
  input  wire                        cfg_we,
  input  wire  [FD_WIDTH-1:0]        cfg_data,
  input  wire  rc_cmd_t              cmd,
  output rc_status_t                 status,
  output logic                       symbol_valid,
  output logic [KIND_WIDTH-1:0]      symbol_kind,
  output logic [DIGIT_WIDTH-1:0]     digit_value,
  output logic [CHAR_WIDTH-1:0]      char_code,
  output logic                       last_symbol
);

  localparam int CW   = $clog2(INT_WIDTH + 1);
  localparam int AW   = $clog2(INT_WIDTH);
  localparam int DCW  = $clog2(INT_WIDTH);
  localparam int FCW  = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int PW   = FRAC_WIDTH + DIGIT_WIDTH;

  logic [FD_WIDTH-1:0]    nf_cfg;
  logic [DIGIT_WIDTH-1:0] base_reg;
  logic                   neg_nz;
  logic                   frac_nz;
  logic [INT_WIDTH-1:0]   quotient_reg;
  logic [DIGIT_WIDTH-1:0] rem;
  logic [DCW-1:0]         div_cnt;
  logic [CW-1:0]          digit_count;
  logic [DIGIT_WIDTH-1:0] digit_buffer [INT_WIDTH];
  logic [DIGIT_WIDTH-1:0] rd_data;
  logic [PW-1:0]          fraction_acc;
  logic [PW-1:0]          mcand;
  logic [DIGIT_WIDTH-1:0] mult;
  logic [MCNT_WIDTH-1:0]  mul_cnt;
  logic [FCW-1:0]         frac_left;

  logic [DIGIT_WIDTH:0]   rem_sh;
  logic                   q_bit;
  logic [DIGIT_WIDTH:0]   rem_next;
  logic [FCW-1:0]         nf_sat;
  logic                   base_small;
  logic [DIGIT_WIDTH-1:0] frac_digit;
  logic [DIGIT_WIDTH-1:0] val_next;
  logic [CHAR_WIDTH-1:0]  char_next;

  // restoring division step
  always_comb begin
    rem_sh   = {rem, quotient_reg[INT_WIDTH-1]};
    q_bit    = (rem_sh >= {1'b0, base_reg});
    rem_next = q_bit ? (rem_sh - {1'b0, base_reg}) : rem_sh;
  end

  always_comb begin
    if ({{(32-FD_WIDTH){1'b0}}, nf_cfg} > 32'(MAX_FRAC_DIGITS)) begin
      nf_sat = FCW'(MAX_FRAC_DIGITS);
    end else begin
      nf_sat = FCW'(nf_cfg);
    end
  end

  assign base_small = (base_reg < BASE_ASCII);
  assign frac_digit = fraction_acc[PW-1:FRAC_WIDTH];

  always_comb begin
    val_next  = '0;
    char_next = '0;
    case (cmd.kind)
      KIND_MINUS: begin
        char_next = base_small ? CHAR_MINUS : '0;
      end
      KIND_INT: begin
        val_next  = rd_data;
        char_next = ascii_of(rd_data, base_small);
      end
      KIND_POINT: begin
        char_next = base_small ? CHAR_POINT : '0;
      end
      KIND_FRAC: begin
        val_next  = frac_digit;
        char_next = ascii_of(frac_digit, base_small);
      end
      default: begin
        val_next  = '0;
        char_next = '0;
      end
    endcase
  end

  always_comb begin
    status.bad_base       = (target_base < BASE_MIN);
    status.neg_nz         = neg_nz;
    status.frac_nz        = frac_nz;
    status.div_last       = (div_cnt == '0);
    status.quot_zero      = (quotient_reg == '0);
    status.count_zero     = (digit_count == '0);
    status.frac_left_zero = (frac_left == '0);
    status.frac_left_one  = (frac_left == FCW'(1));
    status.mul_last       = (mul_cnt == '0);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      nf_cfg       <= FD_RESET;
      symbol_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        nf_cfg <= cfg_data;
      end
      symbol_valid <= cmd.emit;
    end
  end

  // digit buffer
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      digit_buffer[digit_count[AW-1:0]] <= rem;
    end
    if (cmd.rd) begin
      rd_data <= digit_buffer[AW'(digit_count - CW'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_reg     <= target_base;
      neg_nz       <= negative && ((int_magnitude != '0) || (fraction != '0));
      frac_nz      <= (fraction != '0);
      quotient_reg <= int_magnitude;
      digit_count  <= '0;
      fraction_acc <= {{DIGIT_WIDTH{1'b0}}, fraction};
      frac_left    <= nf_sat;
    end
    if (cmd.div_init) begin
      rem     <= '0;
      div_cnt <= DCW'(INT_WIDTH - 1);
    end
    if (cmd.div_step) begin
      rem          <= rem_next[DIGIT_WIDTH-1:0];
      quotient_reg <= {quotient_reg[INT_WIDTH-2:0], q_bit};
      div_cnt      <= div_cnt - DCW'(1);
    end
    if (cmd.store) begin
      digit_count <= digit_count + CW'(1);
    end
    if (cmd.rd) begin
      digit_count <= digit_count - CW'(1);
    end
    if (cmd.mul_init) begin
      mcand        <= {{DIGIT_WIDTH{1'b0}}, fraction_acc[FRAC_WIDTH-1:0]};
      fraction_acc <= '0;
      mult         <= base_reg;
      mul_cnt      <= MCNT_WIDTH'(DIGIT_WIDTH - 1);
    end
    if (cmd.mul_step) begin
      if (mult[0]) begin
        fraction_acc <= fraction_acc + mcand;
      end
      mcand   <= {mcand[PW-2:0], 1'b0};
      mult    <= {1'b0, mult[DIGIT_WIDTH-1:1]};
      mul_cnt <= mul_cnt - MCNT_WIDTH'(1);
    end
    if (cmd.frac_next) begin
      frac_left <= frac_left - FCW'(1);
    end
    if (cmd.emit) begin
      symbol_kind <= cmd.kind;
      digit_value <= val_next;
      char_code   <= char_next;
      last_symbol <= cmd.last;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rc_ctrl
// Sequencer of the radix converter: sign, integer digit division and readback,
// radix point and fraction digit multiplication.
// ----------------------------------------------------------------------------
module rc_ctrl import rc_pkg::*; (
  input  wire             clk,
  input  wire             rst,
  input  wire             start,
  output logic            busy,
  input  wire rc_status_t status,
  output rc_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SIGN  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_STORE = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_INT   = 3'd5;
  localparam logic [2:0] S_POINT = 3'd6;
  localparam logic [2:0] S_MUL   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       in_frac;
  logic       in_frac_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    in_frac_next = in_frac;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (status.bad_base) begin
            cmd.emit = 1'b1;
            cmd.kind = KIND_BAD;
            cmd.last = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = S_SIGN;
          end
        end
      end
      S_SIGN: begin
        cmd.emit     = status.neg_nz;
        cmd.kind     = KIND_MINUS;
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (!status.quot_zero) begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end else begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_INT;
      end
      S_INT: begin
        cmd.emit = 1'b1;
        cmd.kind = KIND_INT;
        cmd.last = status.count_zero && !status.frac_nz;
        if (!status.count_zero) begin
          state_next = S_RD;
        end else if (status.frac_nz) begin
          state_next = S_POINT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_POINT: begin
        cmd.emit = 1'b1;
        cmd.kind = KIND_POINT;
        cmd.last = status.frac_left_zero;
        if (status.frac_left_zero) begin
          state_next = S_IDLE;
        end else begin
          cmd.mul_init = 1'b1;
          in_frac_next = 1'b0;
          state_next   = S_MUL;
        end
      end
      S_MUL: begin
        if (in_frac) begin
          // fraction digit ready in the product's upper bits
          cmd.emit      = 1'b1;
          cmd.kind      = KIND_FRAC;
          cmd.last      = status.frac_left_one;
          cmd.frac_next = 1'b1;
          in_frac_next  = 1'b0;
          if (status.frac_left_one) begin
            state_next = S_IDLE;
          end else begin
            cmd.mul_init = 1'b1;
          end
        end else begin
          cmd.mul_step = 1'b1;
          if (status.mul_last) begin
            in_frac_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      in_frac <= 1'b0;
    end else begin
      state   <= state_next;
      in_frac <= in_frac_next;
    end
  end

endmodule
`default_nettype wire
